/* rtl/mma_pkg.sv */
package mma_pkg;

    localparam int DEF_CHANNELS   = 4;
    localparam int DEF_MAX_WINDOW = 32;

    localparam int FUNC_W   = 1;
    localparam int CHAN_W   = 2;
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 6;
    localparam int SUM_W    = SAMPLE_W + LEN_W;
    localparam int DCNT_W   = $clog2(SUM_W + 1);

    localparam logic [LEN_W-1:0] WIN_RESET = LEN_W'(20);

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel_out;
        logic [SAMPLE_W-1:0] average;
    } t_out;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_SKIP  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } t_cmd;

endpackage

/* rtl/mma_front.sv */
module mma_front #(
    parameter int CHANNELS = mma_pkg::DEF_CHANNELS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  mma_pkg::t_in  i_data,
    output logic          o_q_valid,
    output mma_pkg::t_cmd o_q_cmd,
    input  logic          i_q_pop
);

    mma_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;
    mma_pkg::t_cmd cmd;

    always_comb begin
        cmd.channel = i_data.channel;
        cmd.sample  = i_data.sample;
        if (32'(i_data.channel) >= CHANNELS) begin
            cmd.kind = mma_pkg::KIND_SKIP;
        end else if (i_data.func == mma_pkg::FUNC_CLEAR) begin
            cmd.kind = mma_pkg::KIND_CLEAR;
        end else begin
            cmd.kind = mma_pkg::KIND_ADD;
        end
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

/* rtl/mma_div.sv */
module mma_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mma_pkg::SUM_W-1:0]   i_dividend,
    input  logic [mma_pkg::LEN_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [mma_pkg::SUM_W-1:0]   o_quotient
);

    localparam int SW = mma_pkg::SUM_W;
    localparam int LW = mma_pkg::LEN_W;

    logic                      r_busy;
    logic                      r_done;
    logic [mma_pkg::DCNT_W-1:0] r_cnt;
    logic [LW-1:0]             r_rem;
    logic [SW-1:0]             r_quo;
    logic [LW-1:0]             r_div;
    logic [LW:0]               trial;
    logic [LW:0]               diff;
    logic                      fits;

    assign trial = {r_rem, r_quo[SW-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[LW-1:0] : trial[LW-1:0];
            r_quo <= {r_quo[SW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mma_pkg::DCNT_W'(SW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == mma_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/mma_back.sv */
module mma_back #(
    parameter int CHANNELS   = mma_pkg::DEF_CHANNELS,
    parameter int MAX_WINDOW = mma_pkg::DEF_MAX_WINDOW
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mma_pkg::LEN_W-1:0] i_len,
    input  logic                      i_q_valid,
    input  mma_pkg::t_cmd             i_q_cmd,
    output logic                      o_q_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output mma_pkg::t_out             o_data
);

    localparam int DEPTH  = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(MAX_WINDOW);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW     = mma_pkg::SUM_W;
    localparam int LW     = mma_pkg::LEN_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DIVGO = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                          r_state;
    logic [mma_pkg::SAMPLE_W-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0]                r_valid;
    logic [POS_W-1:0]                r_wpos [CHANNELS];
    logic [CH_W-1:0]                 r_ch;
    logic [mma_pkg::CHAN_W-1:0]      r_och;
    logic [LW-1:0]                   r_idx;
    logic                            r_pend;
    logic [SW-1:0]                   r_sum;
    logic [mma_pkg::SAMPLE_W-1:0]    r_res;
    logic [mma_pkg::SAMPLE_W-1:0]    r_rd_data;
    logic                            r_rd_ok;
    logic                            r_out_valid;
    mma_pkg::t_out                   r_out;

    logic [CH_W-1:0]                 cmd_ch;
    logic [POS_W-1:0]                cur_pos;
    logic [POS_W-1:0]                new_pos;
    logic                            take;
    logic                            do_add;
    logic                            do_clear;
    logic [ADDR_W-1:0]               wr_addr;
    logic [ADDR_W-1:0]               rd_addr;
    logic                            rd_en;
    logic                            div_start;
    logic                            div_done;
    logic [SW-1:0]                   div_quo;
    logic                            load_out;

    assign cmd_ch   = CH_W'(i_q_cmd.channel);
    assign cur_pos  = r_wpos[cmd_ch];
    assign new_pos  = ((32'(cur_pos) + 1) < 32'(i_len)) ? cur_pos + 1'b1 : '0;
    assign take     = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop  = take;
    assign do_add   = take && (i_q_cmd.kind == mma_pkg::KIND_ADD);
    assign do_clear = take && (i_q_cmd.kind == mma_pkg::KIND_CLEAR);
    assign wr_addr  = ADDR_W'(cmd_ch) * ADDR_W'(MAX_WINDOW) + ADDR_W'(new_pos);
    assign rd_en    = (r_state == S_SCAN) && (r_idx < i_len);
    assign rd_addr  = ADDR_W'(r_ch) * ADDR_W'(MAX_WINDOW) + ADDR_W'(r_idx);
    assign div_start = (r_state == S_DIVGO);
    assign load_out = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (do_add) begin
            r_mem[wr_addr] <= i_q_cmd.sample;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_ok   <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wpos[c] <= '0;
            end
        end else if (do_clear) begin
            for (int k = 0; k < DEPTH; k++) begin
                if ((k / MAX_WINDOW) == int'(cmd_ch)) begin
                    r_valid[k] <= 1'b0;
                end
            end
            r_wpos[cmd_ch] <= '0;
        end else if (do_add) begin
            r_valid[wr_addr] <= 1'b1;
            r_wpos[cmd_ch]   <= new_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ch  <= cmd_ch;
            r_och <= i_q_cmd.channel;
            r_idx <= '0;
            r_sum <= '0;
            r_res <= '0;
        end else if (r_state == S_SCAN) begin
            if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_pend) begin
                r_sum <= r_sum + (r_rd_ok ? SW'(r_rd_data) : '0);
            end
        end else if ((r_state == S_DIV) && div_done) begin
            r_res <= div_quo[mma_pkg::SAMPLE_W-1:0];
        end
        if (load_out) begin
            r_out.channel_out <= r_och;
            r_out.average     <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= rd_en;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_state <= do_add ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    if (!rd_en && !r_pend) begin
                        r_state <= S_DIVGO;
                    end
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    mma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (i_len),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* rtl/multichannel_moving_average.sv */
// Multichannel boxcar moving average. Each input transaction names a channel and
// either adds a sample to that channel's window and returns the floor of the window
// average, or clears the window and returns zero. Every input transaction yields
// exactly one output transaction carrying the channel and the average, in order.
// Both channels use valid and stall; a transaction moves when valid is high and
// stall is low. A two-entry command queue sits behind the input, so up to two
// transactions are taken while the datapath is busy or the output is stalled.
// An add goes from the queue to the output register in steps: it writes the sample,
// reads and sums the window out of the single-port sample memory, then starts and
// runs the 22-step restoring divider. A clear or an out-of-range channel goes
// straight to the output register. The next queued transaction starts in the cycle
// after a result is loaded, so the datapath handles one transaction at a time.
// The output register holds its transaction while o_valid is high and i_stall is
// high; the queue keeps accepting until it is full, then raises o_stall.
// Reset clears all windows at once through per-entry valid bits, sets window_len
// to 20 and empties the queue. window_len is written through i_cfg_we and
// i_cfg_wdata; the user must write it only while the block is idle, which the
// block itself does not enforce; windows should be cleared after a change.
module multichannel_moving_average #(
    parameter int CHANNELS   = mma_pkg::DEF_CHANNELS,
    parameter int MAX_WINDOW = mma_pkg::DEF_MAX_WINDOW
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  mma_pkg::t_in              i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output mma_pkg::t_out             o_data,
    input  logic                      i_cfg_we,
    input  logic [mma_pkg::LEN_W-1:0] i_cfg_wdata
);

    logic [mma_pkg::LEN_W-1:0] r_win;
    logic [mma_pkg::LEN_W-1:0] len_eff;
    logic                      q_valid;
    mma_pkg::t_cmd             q_cmd;
    logic                      q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= mma_pkg::WIN_RESET;
        end else if (i_cfg_we) begin
            r_win <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_win == '0) begin
            len_eff = mma_pkg::LEN_W'(1);
        end else if (32'(r_win) > MAX_WINDOW) begin
            len_eff = mma_pkg::LEN_W'(MAX_WINDOW);
        end else begin
            len_eff = r_win;
        end
    end

    mma_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    mma_back #(
        .CHANNELS   (CHANNELS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_len     (len_eff),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule

/* tb/sv/multichannel_moving_average_tb.sv */
module multichannel_moving_average_tb;

    localparam int NCH            = mma_pkg::DEF_CHANNELS;
    localparam int NWIN           = mma_pkg::DEF_MAX_WINDOW;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CFG_SETTLE     = 70;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_ITEMS    = 240;

    class avg_scoreboard;
        logic [mma_pkg::SAMPLE_W-1:0] ring [NCH][NWIN];
        int unsigned                  wr_pos [NCH];
        logic [mma_pkg::LEN_W-1:0]    win_len;
        mma_pkg::t_out                expected_q [$];
        int unsigned                  errors;
        int unsigned                  checked;
        int unsigned                  clears;

        function new();
            for (int c = 0; c < NCH; c++) begin
                for (int i = 0; i < NWIN; i++) ring[c][i] = '0;
                wr_pos[c] = 0;
            end
            win_len = mma_pkg::WIN_RESET;
            errors  = 0;
            checked = 0;
            clears  = 0;
        endfunction

        function void set_window(logic [mma_pkg::LEN_W-1:0] v);
            win_len = v;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_input(mma_pkg::t_in it);
            mma_pkg::t_out             res;
            int unsigned               len;
            int unsigned               pos;
            int unsigned               ch;
            logic [mma_pkg::SUM_W-1:0] acc;

            ch = it.channel;
            res.channel_out = it.channel;
            res.average     = '0;
            if (it.func == mma_pkg::FUNC_CLEAR) begin
                for (int i = 0; i < NWIN; i++) ring[ch][i] = '0;
                wr_pos[ch] = 0;
                clears++;
            end else begin
                len = (win_len == 0) ? 1 : ((win_len > NWIN) ? NWIN : win_len);
                pos = (wr_pos[ch] < len - 1) ? wr_pos[ch] + 1 : 0;
                wr_pos[ch]    = pos;
                ring[ch][pos] = it.sample;
                acc = '0;
                for (int i = 0; i < len; i++) acc += ring[ch][i];
                res.average = mma_pkg::SAMPLE_W'(acc / len);
            end
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(mma_pkg::t_out got);
            mma_pkg::t_out want;

            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing expected: channel %0d average %0d",
                                 got.channel_out, got.average));
            end else begin
                want = expected_q.pop_front();
                checked++;
                if (got.channel_out !== want.channel_out) begin
                    report($sformatf("result %0d channel_out %0d, expected %0d",
                                     checked, got.channel_out, want.channel_out));
                end
                if (got.average !== want.average) begin
                    report($sformatf("result %0d channel %0d average %0d, expected %0d",
                                     checked, want.channel_out, got.average, want.average));
                end
            end
        endtask
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    mma_pkg::t_in              i_data;
    logic                      o_valid;
    logic                      i_stall;
    mma_pkg::t_out             o_data;
    logic                      i_cfg_we;
    logic [mma_pkg::LEN_W-1:0] i_cfg_wdata;

    avg_scoreboard sb = new();
    bit            calm;
    bit            long_hold_done;
    bit            took;
    int unsigned   idle_cycles;
    int unsigned   items_in;
    int unsigned   settings_used;

    multichannel_moving_average u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            took = 1'b0;
            if (i_valid && !o_stall) begin
                sb.note_input(i_data);
                items_in++;
                took = 1'b1;
            end
            if (o_valid && !i_stall) begin
                sb.check_result(o_data);
                took = 1'b1;
            end
            idle_cycles = took ? 0 : idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // The long hold-off lets the command queue fill so that the input is stalled.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && sb.checked >= 150) begin
                long_hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic mma_pkg::t_in mk_item(logic [mma_pkg::FUNC_W-1:0] f, int unsigned ch,
                                             logic [mma_pkg::SAMPLE_W-1:0] s);
        mma_pkg::t_in it;

        it.func    = f;
        it.channel = mma_pkg::CHAN_W'(ch);
        it.sample  = s;
        return it;
    endfunction

    task automatic send_item(mma_pkg::t_in it);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
    endtask

    task automatic write_window(logic [mma_pkg::LEN_W-1:0] v);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (CFG_SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_window(v);
        settings_used++;
    endtask

    task automatic run_phase(logic [mma_pkg::LEN_W-1:0] v, bit clear_first, bit heavy,
                             int n);
        mma_pkg::t_in it;
        int unsigned  r;

        write_window(v);
        if (clear_first) begin
            for (int c = 0; c < NCH; c++) begin
                send_item(mk_item(mma_pkg::FUNC_CLEAR, c, '0));
            end
        end
        for (int k = 0; k < n; k++) begin
            it.func    = ($urandom_range(0, 11) == 0) ? mma_pkg::FUNC_CLEAR
                                                       : mma_pkg::FUNC_ADD;
            it.channel = mma_pkg::CHAN_W'($urandom_range(0, NCH - 1));
            r = $urandom_range(0, 7);
            if (heavy && r < 6) begin
                it.sample = '1;
            end else if (r == 0) begin
                it.sample = '0;
            end else if (r == 1) begin
                it.sample = '1;
            end else begin
                it.sample = mma_pkg::SAMPLE_W'($urandom);
            end
            send_item(it);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        calm        = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Window length is at its reset value of 20 here.
        for (int c = 0; c < NCH; c++) send_item(mk_item(mma_pkg::FUNC_ADD, c, 16'hFFFF));
        send_item(mk_item(mma_pkg::FUNC_ADD,   0, 16'h0000));
        send_item(mk_item(mma_pkg::FUNC_ADD,   1, 16'h8000));
        send_item(mk_item(mma_pkg::FUNC_ADD,   2, 16'h0001));
        send_item(mk_item(mma_pkg::FUNC_ADD,   3, 16'h5555));
        send_item(mk_item(mma_pkg::FUNC_ADD,   3, 16'hAAAA));
        send_item(mk_item(mma_pkg::FUNC_CLEAR, 0, 16'hFFFF));
        send_item(mk_item(mma_pkg::FUNC_ADD,   0, 16'hFFFF));
        send_item(mk_item(mma_pkg::FUNC_CLEAR, 2, 16'h0000));
        send_item(mk_item(mma_pkg::FUNC_ADD,   2, 16'h0001));
        send_item(mk_item(mma_pkg::FUNC_CLEAR, 3, 16'h1234));
        send_item(mk_item(mma_pkg::FUNC_CLEAR, 3, 16'h0000));
        send_item(mk_item(mma_pkg::FUNC_ADD,   1, 16'h7FFF));
        send_item(mk_item(mma_pkg::FUNC_ADD,   3, 16'hFFFF));

        run_phase(mma_pkg::LEN_W'(1),  1'b1, 1'b0, PHASE_ITEMS);
        run_phase(mma_pkg::LEN_W'(32), 1'b1, 1'b0, PHASE_ITEMS);
        run_phase(mma_pkg::LEN_W'(0),  1'b0, 1'b0, PHASE_ITEMS);
        run_phase(mma_pkg::LEN_W'(63), 1'b0, 1'b1, PHASE_ITEMS);
        run_phase(mma_pkg::LEN_W'(5),  1'b0, 1'b0, PHASE_ITEMS);
        run_phase(mma_pkg::LEN_W'($urandom_range(2, 31)), 1'b1, 1'b0, PHASE_ITEMS);
        run_phase(mma_pkg::LEN_W'(17), 1'b1, 1'b0, PHASE_ITEMS);
        calm = 1'b1;
        run_phase(mma_pkg::LEN_W'(32), 1'b1, 1'b0, PHASE_ITEMS);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);

        $display("Summary: %0d transactions in, %0d results checked, %0d of them clears.",
                 items_in, sb.checked, sb.clears);
        $display("Summary: %0d window settings incl. 0, 1, 32 and 63, some without clearing.",
                 settings_used + 1);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
